### design/bffrp_pkg.sv
// ----------------------------------------------------------------------------
// bffrp_pkg: shared types, constants and microcode for the rectangle placer
// Holds the control word layout, the step codes of the sequencer program and
// the program itself as a constant table.
// ----------------------------------------------------------------------------
`default_nettype none

package bffrp_pkg;

  // Default grid side
  localparam int MAX_SIDE_DEF = 256;

  // Configuration register indexes
  localparam logic CFG_ATLAS_SIDE = 1'b0;
  localparam logic CFG_SPACING    = 1'b1;

  localparam int CFG_DW = 9;

  // Request codes
  localparam logic ACT_PLACE = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
  localparam logic [OP_W-1:0] OP_CLR_ROW  = 4'd1;
  localparam logic [OP_W-1:0] OP_LATCH    = 4'd2;
  localparam logic [OP_W-1:0] OP_SET_Y1   = 4'd3;
  localparam logic [OP_W-1:0] OP_SET_X1   = 4'd4;
  localparam logic [OP_W-1:0] OP_CLR_R    = 4'd5;
  localparam logic [OP_W-1:0] OP_RD_ROW   = 4'd6;
  localparam logic [OP_W-1:0] OP_LOAD_ROW = 4'd7;
  localparam logic [OP_W-1:0] OP_ADV_C    = 4'd8;
  localparam logic [OP_W-1:0] OP_ADV_R    = 4'd9;
  localparam logic [OP_W-1:0] OP_ADV_X    = 4'd10;
  localparam logic [OP_W-1:0] OP_ADV_Y    = 4'd11;
  localparam logic [OP_W-1:0] OP_SET_BIT  = 4'd12;
  localparam logic [OP_W-1:0] OP_WR_ROW   = 4'd13;
  localparam logic [OP_W-1:0] OP_OUT_HIT  = 4'd14;
  localparam logic [OP_W-1:0] OP_OUT_MISS = 4'd15;

  // Jump conditions
  localparam int CD_W = 4;
  localparam logic [CD_W-1:0] C_ALWAYS     = 4'd0;
  localparam logic [CD_W-1:0] C_ACCEPT     = 4'd1;
  localparam logic [CD_W-1:0] C_IS_CLEAR   = 4'd2;
  localparam logic [CD_W-1:0] C_CLR_LAST   = 4'd3;
  localparam logic [CD_W-1:0] C_ROW_OUT    = 4'd4;
  localparam logic [CD_W-1:0] C_COL_OUT    = 4'd5;
  localparam logic [CD_W-1:0] C_BUSY       = 4'd6;
  localparam logic [CD_W-1:0] C_C_MORE     = 4'd7;
  localparam logic [CD_W-1:0] C_C_SUM_MORE = 4'd8;
  localparam logic [CD_W-1:0] C_R_MORE     = 4'd9;
  localparam logic [CD_W-1:0] C_OUT_FREE   = 4'd10;

  // Program steps
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] S_RCLR  = 5'd0;
  localparam logic [PC_W-1:0] S_IDLE  = 5'd1;
  localparam logic [PC_W-1:0] S_DISP  = 5'd2;
  localparam logic [PC_W-1:0] S_CLR   = 5'd3;
  localparam logic [PC_W-1:0] S_INIT  = 5'd4;
  localparam logic [PC_W-1:0] S_YCHK  = 5'd5;
  localparam logic [PC_W-1:0] S_XCHK  = 5'd6;
  localparam logic [PC_W-1:0] S_RROW  = 5'd7;
  localparam logic [PC_W-1:0] S_RLOAD = 5'd8;
  localparam logic [PC_W-1:0] S_CCHK  = 5'd9;
  localparam logic [PC_W-1:0] S_CTEST = 5'd10;
  localparam logic [PC_W-1:0] S_RNEXT = 5'd11;
  localparam logic [PC_W-1:0] S_XNEXT = 5'd12;
  localparam logic [PC_W-1:0] S_YNEXT = 5'd13;
  localparam logic [PC_W-1:0] S_MINIT = 5'd14;
  localparam logic [PC_W-1:0] S_MROW  = 5'd15;
  localparam logic [PC_W-1:0] S_MLOAD = 5'd16;
  localparam logic [PC_W-1:0] S_MSET  = 5'd17;
  localparam logic [PC_W-1:0] S_MWR   = 5'd18;
  localparam logic [PC_W-1:0] S_SUCC  = 5'd19;
  localparam logic [PC_W-1:0] S_FAIL  = 5'd20;

  // One control word: operation, condition, target when true, target when false
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [CD_W-1:0] cond;
    logic [PC_W-1:0] tgt_t;
    logic [PC_W-1:0] tgt_f;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    logic            idle;
    logic [OP_W-1:0] op;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic is_clear;
    logic clr_last;
    logic row_out;
    logic col_out;
    logic busy;
    logic c_more;
    logic c_sum_more;
    logic r_more;
    logic out_free;
  } stat_t;

  function automatic ucode_t uw(input logic [OP_W-1:0] op, input logic [CD_W-1:0] cond,
                                input logic [PC_W-1:0] tgt_t,
                                input logic [PC_W-1:0] tgt_f);
    ucode_t w;
    w.op    = op;
    w.cond  = cond;
    w.tgt_t = tgt_t;
    w.tgt_f = tgt_f;
    return w;
  endfunction

  // Placement program
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      S_RCLR:  w = uw(OP_CLR_ROW,  C_CLR_LAST,   S_IDLE,  S_RCLR);
      S_IDLE:  w = uw(OP_LATCH,    C_ACCEPT,     S_DISP,  S_IDLE);
      S_DISP:  w = uw(OP_NOP,      C_IS_CLEAR,   S_CLR,   S_INIT);
      S_CLR:   w = uw(OP_CLR_ROW,  C_CLR_LAST,   S_FAIL,  S_CLR);
      S_INIT:  w = uw(OP_SET_Y1,   C_ALWAYS,     S_YCHK,  S_YCHK);
      S_YCHK:  w = uw(OP_SET_X1,   C_ROW_OUT,    S_FAIL,  S_XCHK);
      S_XCHK:  w = uw(OP_CLR_R,    C_COL_OUT,    S_YNEXT, S_RROW);
      S_RROW:  w = uw(OP_RD_ROW,   C_ALWAYS,     S_RLOAD, S_RLOAD);
      S_RLOAD: w = uw(OP_LOAD_ROW, C_ALWAYS,     S_CCHK,  S_CCHK);
      S_CCHK:  w = uw(OP_ADV_C,    C_BUSY,       S_XNEXT, S_CTEST);
      S_CTEST: w = uw(OP_NOP,      C_C_MORE,     S_CCHK,  S_RNEXT);
      S_RNEXT: w = uw(OP_ADV_R,    C_R_MORE,     S_RROW,  S_MINIT);
      S_XNEXT: w = uw(OP_ADV_X,    C_ALWAYS,     S_XCHK,  S_XCHK);
      S_YNEXT: w = uw(OP_ADV_Y,    C_ALWAYS,     S_YCHK,  S_YCHK);
      S_MINIT: w = uw(OP_CLR_R,    C_ALWAYS,     S_MROW,  S_MROW);
      S_MROW:  w = uw(OP_RD_ROW,   C_ALWAYS,     S_MLOAD, S_MLOAD);
      S_MLOAD: w = uw(OP_LOAD_ROW, C_ALWAYS,     S_MSET,  S_MSET);
      S_MSET:  w = uw(OP_SET_BIT,  C_C_SUM_MORE, S_MSET,  S_MWR);
      S_MWR:   w = uw(OP_WR_ROW,   C_R_MORE,     S_MROW,  S_SUCC);
      S_SUCC:  w = uw(OP_OUT_HIT,  C_OUT_FREE,   S_IDLE,  S_SUCC);
      S_FAIL:  w = uw(OP_OUT_MISS, C_OUT_FREE,   S_IDLE,  S_FAIL);
      default: w = uw(OP_NOP,      C_ALWAYS,     S_IDLE,  S_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### design/bffrp_ram.sv
// ----------------------------------------------------------------------------
// bffrp_ram: generic single-port RAM
// One address per cycle, write or registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bffrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                       clk,
  input  wire                       wr_en,
  input  wire                       rd_en,
  input  wire [$clog2(DEPTH)-1:0]   addr,
  input  wire [WIDTH-1:0]           wr_data,
  output logic [WIDTH-1:0]          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### design/bffrp_useq.sv
// ----------------------------------------------------------------------------
// bffrp_useq: microcode sequencer
// Step counter over the placement program, one conditional jump per step.
// ----------------------------------------------------------------------------
`default_nettype none

module bffrp_useq
  import bffrp_pkg::*;
(
  input  wire    clk,
  input  wire    rst_n,
  input  wire    in_valid,
  input  stat_t  stat,
  output ctrl_t  ctrl
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  ucode_t          word;
  logic            cond_hit;

  // Fetch the control word
  assign word = ucode_rom(pc_r);

  // Select the jump condition
  always_comb begin
    unique case (word.cond)
      C_ALWAYS:     cond_hit = 1'b1;
      C_ACCEPT:     cond_hit = in_valid;
      C_IS_CLEAR:   cond_hit = stat.is_clear;
      C_CLR_LAST:   cond_hit = stat.clr_last;
      C_ROW_OUT:    cond_hit = stat.row_out;
      C_COL_OUT:    cond_hit = stat.col_out;
      C_BUSY:       cond_hit = stat.busy;
      C_C_MORE:     cond_hit = stat.c_more;
      C_C_SUM_MORE: cond_hit = stat.c_sum_more;
      C_R_MORE:     cond_hit = stat.r_more;
      C_OUT_FREE:   cond_hit = stat.out_free;
      default:      cond_hit = 1'b0;
    endcase
  end

  assign pc_nxt    = cond_hit ? word.tgt_t : word.tgt_f;
  assign ctrl.op   = word.op;
  assign ctrl.idle = (pc_r == S_IDLE);

  // Advance the step counter; start with the grid clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_RCLR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // Dispatch only follows an accepted transaction
  a_disp_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_DISP) |-> $past(pc_r == S_IDLE && in_valid))
    else $error("dispatch step entered without an accepted transaction");

  // Clearing pass stays in its step until the last row
  a_clr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_CLR && !stat.clr_last) |=> (pc_r == S_CLR))
    else $error("clear pass left before the last row");

endmodule

`default_nettype wire

### design/bffrp_dpath.sv
// ----------------------------------------------------------------------------
// bffrp_dpath: placer datapath
// Request registers, scan counters, row buffer, grid RAM and result register,
// all driven by one operation code a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bffrp_dpath
  import bffrp_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  ctrl_t             ctrl,
  output stat_t             stat,
  input  wire [CFG_DW-1:0]  atlas_side,
  input  wire [7:0]         spacing,
  input  wire               in_valid,
  input  wire               in_action,
  input  wire [7:0]         in_rect_width,
  input  wire [7:0]         in_rect_height,
  output logic              out_valid,
  input  wire               out_stall,
  output logic              out_placed,
  output logic [7:0]        out_corner_x,
  output logic [7:0]        out_corner_y
);

  localparam int AW = $clog2(MAX_SIDE);
  localparam int NW = ((AW > 9) ? AW : 9) + 2;

  // Request and scan registers
  logic              action_r, action_nxt;
  logic [NW-1:0]     side_r, side_nxt;
  logic [7:0]        sp_r, sp_nxt;
  logic [NW-1:0]     bw_r, bw_nxt;
  logic [NW-1:0]     bh_r, bh_nxt;
  logic [NW-1:0]     cx_r, cx_nxt;
  logic [NW-1:0]     cy_r, cy_nxt;
  logic [NW-1:0]     r_r, r_nxt;
  logic [NW-1:0]     c_r, c_nxt;
  logic [MAX_SIDE-1:0] rowbuf_r, rowbuf_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_placed_r, out_placed_nxt;
  logic [7:0]        out_x_r, out_x_nxt;
  logic [7:0]        out_y_r, out_y_nxt;

  logic [NW-1:0]     c_sum, r_sum, x_sum, y_sum;
  logic [NW-1:0]     col_pos, row_pos;
  logic [AW-1:0]     col_idx, row_addr;
  logic [NW-1:0]     side_in;
  logic              out_free;
  logic              ram_wr, ram_rd;
  logic [AW-1:0]     ram_addr;
  logic [MAX_SIDE-1:0] ram_wdata, ram_rdata;

  // Stride sums and grid positions
  assign c_sum    = c_r + NW'(sp_r);
  assign r_sum    = r_r + NW'(sp_r);
  assign x_sum    = cx_r + NW'(sp_r);
  assign y_sum    = cy_r + NW'(sp_r);
  assign col_pos  = cx_r + c_r;
  assign row_pos  = cy_r + r_r;
  assign col_idx  = col_pos[AW-1:0];
  assign row_addr = row_pos[AW-1:0];
  assign side_in  = NW'(atlas_side);
  assign out_free = !out_valid_r || !out_stall;

  // Status back to the sequencer
  always_comb begin
    stat.is_clear   = (action_r == ACT_CLEAR);
    stat.clr_last   = (clr_r == AW'(MAX_SIDE - 1));
    stat.row_out    = !(((cy_r + NW'(1)) < side_r) && ((cy_r + bh_r) < side_r));
    stat.col_out    = !(((cx_r + NW'(1)) < side_r) && ((cx_r + bw_r) < side_r));
    stat.busy       = rowbuf_r[col_idx];
    stat.c_more     = (c_r < bw_r);
    stat.c_sum_more = (c_sum < bw_r);
    stat.r_more     = (r_sum < bh_r);
    stat.out_free   = out_free;
  end

  // Grid RAM port: clear rows, read a row, write the marked row back
  assign ram_wr    = (ctrl.op == OP_CLR_ROW) || (ctrl.op == OP_WR_ROW);
  assign ram_rd    = (ctrl.op == OP_RD_ROW);
  assign ram_addr  = (ctrl.op == OP_CLR_ROW) ? clr_r : row_addr;
  assign ram_wdata = (ctrl.op == OP_CLR_ROW) ? '0 : rowbuf_r;

  bffrp_ram #(
    .WIDTH (MAX_SIDE),
    .DEPTH (MAX_SIDE)
  ) u_grid (
    .clk     (clk),
    .wr_en   (ram_wr),
    .rd_en   (ram_rd),
    .addr    (ram_addr),
    .wr_data (ram_wdata),
    .rd_data (ram_rdata)
  );

  // Next-value logic, one operation per cycle
  always_comb begin
    action_nxt     = action_r;
    side_nxt       = side_r;
    sp_nxt         = sp_r;
    bw_nxt         = bw_r;
    bh_nxt         = bh_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    r_nxt          = r_r;
    c_nxt          = c_r;
    rowbuf_nxt     = rowbuf_r;
    clr_nxt        = clr_r;
    out_placed_nxt = out_placed_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_valid_nxt  = out_valid_r && out_stall;

    unique case (ctrl.op)
      OP_CLR_ROW: begin
        clr_nxt = (clr_r == AW'(MAX_SIDE - 1)) ? '0 : clr_r + AW'(1);
      end
      OP_LATCH: begin
        if (in_valid) begin
          action_nxt = in_action;
          side_nxt   = (side_in > NW'(MAX_SIDE)) ? NW'(MAX_SIDE) : side_in;
          sp_nxt     = (spacing == 8'd0) ? 8'd1 : ((spacing > 8'd128) ? 8'd128 : spacing);
          bw_nxt     = NW'(in_rect_width) + NW'(1);
          bh_nxt     = NW'(in_rect_height) + NW'(1);
        end
      end
      OP_SET_Y1:   cy_nxt = NW'(1);
      OP_SET_X1:   cx_nxt = NW'(1);
      OP_CLR_R:    r_nxt  = '0;
      OP_LOAD_ROW: begin
        rowbuf_nxt = ram_rdata;
        c_nxt      = '0;
      end
      OP_ADV_C:    c_nxt  = c_sum;
      OP_ADV_R:    r_nxt  = r_sum;
      OP_ADV_X:    cx_nxt = x_sum;
      OP_ADV_Y:    cy_nxt = y_sum;
      OP_SET_BIT: begin
        rowbuf_nxt[col_idx] = 1'b1;
        c_nxt               = c_sum;
      end
      OP_WR_ROW:   r_nxt  = r_sum;
      OP_OUT_HIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_placed_nxt = 1'b1;
          out_x_nxt      = cx_r[7:0];
          out_y_nxt      = cy_r[7:0];
        end
      end
      OP_OUT_MISS: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_placed_nxt = 1'b0;
          out_x_nxt      = 8'd0;
          out_y_nxt      = 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    side_r       <= side_nxt;
    sp_r         <= sp_nxt;
    bw_r         <= bw_nxt;
    bh_r         <= bh_nxt;
    cx_r         <= cx_nxt;
    cy_r         <= cy_nxt;
    r_r          <= r_nxt;
    c_r          <= c_nxt;
    rowbuf_r     <= rowbuf_nxt;
    out_placed_r <= out_placed_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_placed   = out_placed_r;
  assign out_corner_x = out_x_r;
  assign out_corner_y = out_y_r;

  // Marking never touches a column outside the grid in use
  a_mark_in_side: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_SET_BIT) |-> (col_pos < side_r))
    else $error("marked column beyond grid side");

  // Row accesses stay inside the grid in use
  a_row_in_side: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_RD_ROW || ctrl.op == OP_WR_ROW) |-> (row_pos < side_r))
    else $error("row access beyond grid side");

endmodule

`default_nettype wire

### design/bitmap_first_fit_rect_placer.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_rect_placer: first-fit rectangle placer on an occupancy grid
//
// Input channel (in_valid / in_stall) carries one request per transaction:
// in_action selects place or clear, in_rect_width / in_rect_height the size.
// Every request yields exactly one result transaction on the output channel
// (out_valid / out_stall): out_placed and the corner, or zeros on failure or
// after a clear. One request is in work at a time; in_stall is low only while
// the sequencer waits for work, including while a result is still held.
// The scan runs dispatch, then a check of each candidate row and column; for
// each candidate, every sampled box row is read and its sampled cells tested,
// and a marked cell rejects the candidate. On a hit, every sampled row of the
// box is marked and written back, then the result is registered. A clear
// request writes one grid row per cycle and then yields its result; the next
// request can be taken once a result is registered. After reset the grid is
// cleared row by row in a pass during which no request is taken;
// configuration writes (cfg_wr_en, cfg_index, cfg_wr_data) are taken at any
// time. A stalled result holds in its output register and the sequencer waits
// at its last step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_first_fit_rect_placer
  import bffrp_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_wr_en,
  input  wire               cfg_index,
  input  wire [CFG_DW-1:0]  cfg_wr_data,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               in_action,
  input  wire [7:0]         in_rect_width,
  input  wire [7:0]         in_rect_height,
  output logic              out_valid,
  input  wire               out_stall,
  output logic              out_placed,
  output logic [7:0]        out_corner_x,
  output logic [7:0]        out_corner_y
);

  logic [CFG_DW-1:0] atlas_side_r, atlas_side_nxt;
  logic [7:0]        spacing_r, spacing_nxt;
  ctrl_t             ctrl;
  stat_t             stat;

  // Configuration register writes
  always_comb begin
    atlas_side_nxt = atlas_side_r;
    spacing_nxt    = spacing_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ATLAS_SIDE: atlas_side_nxt = cfg_wr_data;
        CFG_SPACING:    spacing_nxt    = cfg_wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_side_r <= CFG_DW'(256);
      spacing_r    <= 8'd1;
    end else begin
      atlas_side_r <= atlas_side_nxt;
      spacing_r    <= spacing_nxt;
    end
  end

  // Take a request only while the sequencer waits for one
  assign in_stall = !ctrl.idle;

  bffrp_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  bffrp_dpath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .stat           (stat),
    .atlas_side     (atlas_side_r),
    .spacing        (spacing_r),
    .in_valid       (in_valid),
    .in_action      (in_action),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_placed     (out_placed),
    .out_corner_x   (out_corner_x),
    .out_corner_y   (out_corner_y)
  );

  // A new result only appears from a result step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctrl.op == OP_OUT_HIT || ctrl.op == OP_OUT_MISS))
    else $error("result raised outside a result step");

  // No request taken while a previous one is in work
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken before the first finished");

endmodule

`default_nettype wire
